// ===== src/cbps_pkg.sv =====
// ----------------------------------------------------------------------------
// cbps_pkg
// shared widths, codes and types of the cubic bezier point sampler
// ----------------------------------------------------------------------------
`default_nettype none

package cbps_pkg;

    localparam int COORD_BITS     = 13;
    localparam int STEP_BITS      = COORD_BITS + 1;
    localparam int SQ_BITS        = 2 * COORD_BITS + 2;
    localparam int MUL_A_BITS     = 3 * COORD_BITS + 3;
    localparam int MUL_B_BITS     = COORD_BITS + 2;
    localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS + 1;
    localparam int ACC_BITS       = 4 * COORD_BITS + 3;
    localparam int REM_BITS       = 4 * COORD_BITS + 2;
    localparam int DIV_CNT_BITS   = $clog2(COORD_BITS);
    localparam int CFG_IDX_BITS   = 4;
    localparam int JOB_FIFO_DEPTH = 2;
    localparam int FIFO_PTR_BITS  = $clog2(JOB_FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(JOB_FIFO_DEPTH + 1);

    localparam logic [DIV_CNT_BITS-1:0]  DIV_TOP  = DIV_CNT_BITS'(COORD_BITS - 1);
    localparam logic [STEP_BITS-1:0]     STEP_ONE = STEP_BITS'(1);
    localparam logic [FIFO_PTR_BITS-1:0] PTR_TOP  = FIFO_PTR_BITS'(JOB_FIFO_DEPTH - 1);
    localparam logic [FIFO_CNT_BITS-1:0] CNT_FULL = FIFO_CNT_BITS'(JOB_FIFO_DEPTH);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_CTRL_A_X,
        CFG_CTRL_A_Y,
        CFG_CTRL_B_X,
        CFG_CTRL_B_Y,
        CFG_END_X,
        CFG_END_Y
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ROUND,
        ST_DONE
    } t_eval_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p0x;
        logic signed [COORD_BITS-1:0] p0y;
        logic signed [COORD_BITS-1:0] p1x;
        logic signed [COORD_BITS-1:0] p1y;
        logic signed [COORD_BITS-1:0] p2x;
        logic signed [COORD_BITS-1:0] p2y;
        logic signed [COORD_BITS-1:0] p3x;
        logic signed [COORD_BITS-1:0] p3y;
    } t_points;

    typedef struct packed {
        logic [STEP_BITS-1:0] steps;
        logic [STEP_BITS-1:0] index;
        logic                 last;
    } t_job;

endpackage

`default_nettype wire

// ===== src/cbps_front.sv =====
// ----------------------------------------------------------------------------
// cbps_front
// takes tick requests, works out step count and sample index, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module cbps_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_restart,
    input  wire logic                i_cfg_wr,
    input  wire cbps_pkg::t_points   i_pts,
    output logic                     o_push,
    output cbps_pkg::t_job           o_job,
    input  wire logic                i_full
);

    function automatic logic [cbps_pkg::STEP_BITS-1:0] abs_diff(
        input logic signed [cbps_pkg::COORD_BITS-1:0] a,
        input logic signed [cbps_pkg::COORD_BITS-1:0] b
    );
        logic signed [cbps_pkg::COORD_BITS:0] d;
        d = {a[cbps_pkg::COORD_BITS-1], a} - {b[cbps_pkg::COORD_BITS-1], b};
        return d[cbps_pkg::COORD_BITS] ? -d : d;
    endfunction

    logic [cbps_pkg::STEP_BITS-1:0] dist_se;
    logic [cbps_pkg::STEP_BITS-1:0] dist_sa;
    logic [cbps_pkg::STEP_BITS-1:0] dist_eb;
    logic [cbps_pkg::STEP_BITS-1:0] steps_c;
    logic [cbps_pkg::STEP_BITS-1:0] r_steps;
    logic                           r_steps_stale;
    logic [cbps_pkg::STEP_BITS-1:0] r_count;
    logic [cbps_pkg::STEP_BITS-1:0] n_count;
    logic [cbps_pkg::STEP_BITS-1:0] idx_c;
    logic                           last_c;

    assign dist_se = abs_diff(i_pts.p3x, i_pts.p0x) + abs_diff(i_pts.p3y, i_pts.p0y);
    assign dist_sa = abs_diff(i_pts.p1x, i_pts.p0x) + abs_diff(i_pts.p1y, i_pts.p0y);
    assign dist_eb = abs_diff(i_pts.p2x, i_pts.p3x) + abs_diff(i_pts.p2y, i_pts.p3y);

    always_comb begin
        steps_c = cbps_pkg::STEP_ONE;
        if (dist_se > steps_c) begin
            steps_c = dist_se;
        end
        if (dist_sa > steps_c) begin
            steps_c = dist_sa;
        end
        if (dist_eb > steps_c) begin
            steps_c = dist_eb;
        end
    end

    // step count is registered from the stored control points, so it lags a register write
    always_ff @(posedge i_clk) begin
        r_steps <= steps_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_stale <= 1'b1;
        end else begin
            r_steps_stale <= i_cfg_wr;
        end
    end

    always_comb begin
        idx_c = i_restart ? cbps_pkg::STEP_ONE : r_count + cbps_pkg::STEP_ONE;
        if (idx_c > r_steps) begin
            idx_c = cbps_pkg::STEP_ONE;
        end
        last_c  = (idx_c == r_steps);
        n_count = last_c ? '0 : idx_c;
    end

    assign o_stall     = i_full || r_steps_stale;
    assign o_push      = i_valid && !o_stall;
    assign o_job.steps = r_steps;
    assign o_job.index = idx_c;
    assign o_job.last  = last_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.index != '0) && (o_job.index <= o_job.steps))
        else $error("sample index outside 1..steps");

    a_last_resets_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.last) |=> (r_count == '0))
        else $error("counter not cleared after last sample");

    a_stale_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> !o_push)
        else $error("request taken with stale step count");

endmodule

`default_nettype wire

// ===== src/cbps_job_fifo.sv =====
// ----------------------------------------------------------------------------
// cbps_job_fifo
// short job queue between the front and the evaluator
// ----------------------------------------------------------------------------
`default_nettype none

module cbps_job_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cbps_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output cbps_pkg::t_job       o_job,
    output logic                 o_not_empty,
    output logic                 o_full
);

    cbps_pkg::t_job                       r_mem [cbps_pkg::JOB_FIFO_DEPTH];
    logic [cbps_pkg::FIFO_PTR_BITS-1:0]   r_wr_ptr;
    logic [cbps_pkg::FIFO_PTR_BITS-1:0]   r_rd_ptr;
    logic [cbps_pkg::FIFO_CNT_BITS-1:0]   r_cnt;
    logic                                 do_push;
    logic                                 do_pop;

    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_not_empty = (r_cnt != '0);
    assign o_full      = (r_cnt == cbps_pkg::CNT_FULL);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == cbps_pkg::PTR_TOP) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == cbps_pkg::PTR_TOP) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/cbps_eval.sv =====
// ----------------------------------------------------------------------------
// cbps_eval
// bernstein sum on a shared multiplier, then a bit-serial rounding divide
// ----------------------------------------------------------------------------
`default_nettype none

module cbps_eval (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_job_valid,
    input  wire cbps_pkg::t_job                         i_job,
    output logic                                        o_job_pop,
    input  wire cbps_pkg::t_points                      i_pts,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [cbps_pkg::COORD_BITS-1:0]      o_sample_x,
    output logic signed [cbps_pkg::COORD_BITS-1:0]      o_sample_y,
    output logic [cbps_pkg::STEP_BITS-1:0]              o_step_index,
    output logic                                        o_last
);

    typedef enum logic [4:0] {
        MS_UU, MS_TT, MS_UUU, MS_UUT, MS_TTU, MS_TTT, MS_SS, MS_SSS,
        MS_X0, MS_X1, MS_X2, MS_X3, MS_Y0, MS_Y1, MS_Y2, MS_Y3, MS_FLUSH
    } t_mstep;

    typedef enum logic {
        AXIS_X,
        AXIS_Y
    } t_axis;

    cbps_pkg::t_eval_state                  r_state;
    cbps_pkg::t_eval_state                  n_state;
    t_mstep                                 r_step;
    t_axis                                  r_axis;
    cbps_pkg::t_job                         r_job;

    logic [cbps_pkg::STEP_BITS-1:0]         u_c;
    logic [cbps_pkg::STEP_BITS-1:0]         t_c;
    logic [cbps_pkg::MUL_A_BITS-1:0]        mul_a;
    logic signed [cbps_pkg::MUL_B_BITS-1:0] mul_b;
    logic signed [cbps_pkg::PROD_BITS-1:0]  mul_full;
    logic signed [cbps_pkg::ACC_BITS-1:0]   r_prod;
    logic [cbps_pkg::MUL_A_BITS-1:0]        prod_a;
    logic [cbps_pkg::MUL_A_BITS-1:0]        prod_x3;

    logic [cbps_pkg::SQ_BITS-1:0]           r_sq_u;
    logic [cbps_pkg::SQ_BITS-1:0]           r_sq_t;
    logic [cbps_pkg::MUL_A_BITS-1:0]        r_w [4];
    logic [cbps_pkg::MUL_A_BITS-1:0]        r_s3;
    logic signed [cbps_pkg::ACC_BITS-1:0]   r_acc_x;
    logic signed [cbps_pkg::ACC_BITS-1:0]   r_acc_y;

    logic signed [cbps_pkg::ACC_BITS-1:0]   div_src;
    logic signed [cbps_pkg::ACC_BITS-1:0]   div_mag;
    logic [cbps_pkg::REM_BITS-1:0]          r_rem;
    logic [cbps_pkg::REM_BITS-1:0]          r_div;
    logic [cbps_pkg::COORD_BITS-1:0]        r_quo;
    logic [cbps_pkg::DIV_CNT_BITS-1:0]      r_cnt;
    logic                                   r_neg;
    logic                                   sub_ok;
    logic                                   round_up;
    logic [cbps_pkg::COORD_BITS-1:0]        q_rnd;
    logic signed [cbps_pkg::COORD_BITS-1:0] res_c;
    logic signed [cbps_pkg::COORD_BITS-1:0] r_res_x;
    logic signed [cbps_pkg::COORD_BITS-1:0] r_res_y;

    logic                                   out_load;
    logic                                   r_out_valid;

    assign u_c = r_job.steps - r_job.index;
    assign t_c = r_job.index;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            MS_UU: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::STEP_BITS){1'b0}}, u_c};
                mul_b = {1'b0, u_c};
            end
            MS_TT: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::STEP_BITS){1'b0}}, t_c};
                mul_b = {1'b0, t_c};
            end
            MS_UUU: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::SQ_BITS){1'b0}}, r_sq_u};
                mul_b = {1'b0, u_c};
            end
            MS_UUT: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::SQ_BITS){1'b0}}, r_sq_u};
                mul_b = {1'b0, t_c};
            end
            MS_TTU: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::SQ_BITS){1'b0}}, r_sq_t};
                mul_b = {1'b0, u_c};
            end
            MS_TTT: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::SQ_BITS){1'b0}}, r_sq_t};
                mul_b = {1'b0, t_c};
            end
            MS_SS: begin
                mul_a = {{(cbps_pkg::MUL_A_BITS-cbps_pkg::STEP_BITS){1'b0}}, r_job.steps};
                mul_b = {1'b0, r_job.steps};
            end
            MS_SSS: begin
                mul_a = prod_a;
                mul_b = {1'b0, r_job.steps};
            end
            MS_X0: begin
                mul_a = r_w[0];
                mul_b = {{2{i_pts.p0x[cbps_pkg::COORD_BITS-1]}}, i_pts.p0x};
            end
            MS_X1: begin
                mul_a = r_w[1];
                mul_b = {{2{i_pts.p1x[cbps_pkg::COORD_BITS-1]}}, i_pts.p1x};
            end
            MS_X2: begin
                mul_a = r_w[2];
                mul_b = {{2{i_pts.p2x[cbps_pkg::COORD_BITS-1]}}, i_pts.p2x};
            end
            MS_X3: begin
                mul_a = r_w[3];
                mul_b = {{2{i_pts.p3x[cbps_pkg::COORD_BITS-1]}}, i_pts.p3x};
            end
            MS_Y0: begin
                mul_a = r_w[0];
                mul_b = {{2{i_pts.p0y[cbps_pkg::COORD_BITS-1]}}, i_pts.p0y};
            end
            MS_Y1: begin
                mul_a = r_w[1];
                mul_b = {{2{i_pts.p1y[cbps_pkg::COORD_BITS-1]}}, i_pts.p1y};
            end
            MS_Y2: begin
                mul_a = r_w[2];
                mul_b = {{2{i_pts.p2y[cbps_pkg::COORD_BITS-1]}}, i_pts.p2y};
            end
            MS_Y3: begin
                mul_a = r_w[3];
                mul_b = {{2{i_pts.p3y[cbps_pkg::COORD_BITS-1]}}, i_pts.p3y};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = $signed({1'b0, mul_a}) * mul_b;
    assign prod_a   = r_prod[cbps_pkg::MUL_A_BITS-1:0];
    assign prod_x3  = {prod_a[cbps_pkg::MUL_A_BITS-2:0], 1'b0} + prod_a;

    // divider
    assign div_src  = (r_state == cbps_pkg::ST_MUL) ? r_acc_x : r_acc_y;
    assign div_mag  = div_src[cbps_pkg::ACC_BITS-1] ? -div_src : div_src;
    assign sub_ok   = (r_rem >= r_div);
    assign round_up = ({r_rem[cbps_pkg::MUL_A_BITS-1:0], 1'b0} >= {1'b0, r_s3});
    assign q_rnd    = r_quo + {{(cbps_pkg::COORD_BITS-1){1'b0}}, round_up};
    assign res_c    = r_neg ? -q_rnd : q_rnd;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cbps_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = cbps_pkg::ST_MUL;
                end
            end
            cbps_pkg::ST_MUL: begin
                if (r_step == MS_FLUSH) begin
                    n_state = cbps_pkg::ST_DIV;
                end
            end
            cbps_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = cbps_pkg::ST_ROUND;
                end
            end
            cbps_pkg::ST_ROUND: begin
                n_state = (r_axis == AXIS_X) ? cbps_pkg::ST_DIV : cbps_pkg::ST_DONE;
            end
            cbps_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = cbps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbps_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_job_pop = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            cbps_pkg::ST_IDLE: begin
                o_job_pop = i_job_valid;
            end
            cbps_pkg::ST_DONE: begin
                out_load = !r_out_valid || !i_stall;
            end
            default: begin
                o_job_pop = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbps_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[cbps_pkg::ACC_BITS-1:0];
        case (r_state)
            cbps_pkg::ST_IDLE: begin
                r_job  <= i_job;
                r_step <= MS_UU;
            end
            cbps_pkg::ST_MUL: begin
                r_step <= t_mstep'(r_step + 1'b1);
                case (r_step)
                    MS_TT:  r_sq_u <= r_prod[cbps_pkg::SQ_BITS-1:0];
                    MS_UUU: r_sq_t <= r_prod[cbps_pkg::SQ_BITS-1:0];
                    MS_UUT: r_w[0] <= prod_a;
                    MS_TTU: r_w[1] <= prod_x3;
                    MS_TTT: r_w[2] <= prod_x3;
                    MS_SS:  r_w[3] <= prod_a;
                    MS_X0:  r_s3   <= prod_a;
                    MS_X1:  r_acc_x <= r_prod;
                    MS_X2, MS_X3, MS_Y0: r_acc_x <= r_acc_x + r_prod;
                    MS_Y1:  r_acc_y <= r_prod;
                    MS_Y2, MS_Y3: r_acc_y <= r_acc_y + r_prod;
                    MS_FLUSH: begin
                        r_acc_y <= r_acc_y + r_prod;
                        r_rem   <= div_mag[cbps_pkg::REM_BITS-1:0];
                        r_neg   <= div_src[cbps_pkg::ACC_BITS-1];
                        r_div   <= {r_s3, {(cbps_pkg::COORD_BITS-1){1'b0}}};
                        r_cnt   <= cbps_pkg::DIV_TOP;
                        r_axis  <= AXIS_X;
                    end
                    default: begin
                        r_acc_x <= r_acc_x;
                    end
                endcase
            end
            cbps_pkg::ST_DIV: begin
                if (sub_ok) begin
                    r_rem <= r_rem - r_div;
                end
                r_quo <= {r_quo[cbps_pkg::COORD_BITS-2:0], sub_ok};
                r_div <= r_div >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            cbps_pkg::ST_ROUND: begin
                if (r_axis == AXIS_X) begin
                    r_res_x <= res_c;
                    r_rem   <= div_mag[cbps_pkg::REM_BITS-1:0];
                    r_neg   <= div_src[cbps_pkg::ACC_BITS-1];
                    r_div   <= {r_s3, {(cbps_pkg::COORD_BITS-1){1'b0}}};
                    r_cnt   <= cbps_pkg::DIV_TOP;
                    r_axis  <= AXIS_Y;
                end else begin
                    r_res_y <= res_c;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        if (out_load) begin
            o_sample_x   <= r_res_x;
            o_sample_y   <= r_res_y;
            o_step_index <= r_job.index;
            o_last       <= r_job.last;
        end
    end

    assign o_valid = r_out_valid;

    a_pop_only_when_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> i_job_valid)
        else $error("job taken from empty queue");

    a_weights_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbps_pkg::ST_DIV) |->
            ({2'b00, r_w[0]} + {2'b00, r_w[1]} + {2'b00, r_w[2]} + {2'b00, r_w[3]})
            == {2'b00, r_s3})
        else $error("bernstein weights do not sum to steps cubed");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbps_pkg::ST_ROUND) |->
            (r_rem < {{(cbps_pkg::REM_BITS-cbps_pkg::MUL_A_BITS){1'b0}}, r_s3}))
        else $error("quotient overflow in divider");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbps_pkg::ST_DONE && r_out_valid && i_stall)
            |=> (r_state == cbps_pkg::ST_DONE))
        else $error("result overwrote a stalled sample");

endmodule

`default_nettype wire

// ===== src/cubic_bezier_point_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_sampler_unit
// samples a cubic bezier curve one point per tick request
// ----------------------------------------------------------------------------
// control points are written over the cfg channel (index 0..7: start x/y,
// first control x/y, second control x/y, end x/y); other indexes are
// dropped. cfg_ready is always high. tick requests are stalled in the cycle
// after a write (and after reset) while the step count settles. each
// request (i_valid, o_stall) gives one sample on the output channel
// (o_valid, i_stall) with coordinates, index and last flag; i_restart makes
// its index 1. the evaluator works through 17 steps in one shared multiplier
// for the bernstein sums, then one quotient bit a cycle in a shared divider
// for x and then y; o_valid rises from the output register once it is done.
// a two-entry job queue and the output register let requests be taken
// while a finished sample is stalled; once the queue is full o_stall holds
// requests off. reset clears the control points to zero and the next
// sample index to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_sampler_unit (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_stall,
    input  wire logic                                     i_restart,
    output logic                                          o_valid,
    input  wire logic                                     i_stall,
    output logic signed [cbps_pkg::COORD_BITS-1:0]        o_sample_x,
    output logic signed [cbps_pkg::COORD_BITS-1:0]        o_sample_y,
    output logic [cbps_pkg::STEP_BITS-1:0]                o_step_index,
    output logic                                          o_last,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [cbps_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  wire logic signed [cbps_pkg::COORD_BITS-1:0]   i_cfg_data
);

    cbps_pkg::t_points r_pts;
    cbps_pkg::t_job    push_job;
    cbps_pkg::t_job    head_job;
    logic              cfg_wr;
    logic              push;
    logic              pop;
    logic              q_not_empty;
    logic              q_full;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                cbps_pkg::CFG_START_X:  r_pts.p0x <= i_cfg_data;
                cbps_pkg::CFG_START_Y:  r_pts.p0y <= i_cfg_data;
                cbps_pkg::CFG_CTRL_A_X: r_pts.p1x <= i_cfg_data;
                cbps_pkg::CFG_CTRL_A_Y: r_pts.p1y <= i_cfg_data;
                cbps_pkg::CFG_CTRL_B_X: r_pts.p2x <= i_cfg_data;
                cbps_pkg::CFG_CTRL_B_Y: r_pts.p2y <= i_cfg_data;
                cbps_pkg::CFG_END_X:    r_pts.p3x <= i_cfg_data;
                cbps_pkg::CFG_END_Y:    r_pts.p3y <= i_cfg_data;
                default: begin
                    r_pts <= r_pts;
                end
            endcase
        end
    end

    cbps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_restart (i_restart),
        .i_cfg_wr  (cfg_wr),
        .i_pts     (r_pts),
        .o_push    (push),
        .o_job     (push_job),
        .i_full    (q_full)
    );

    cbps_job_fifo u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (push_job),
        .i_pop       (pop),
        .o_job       (head_job),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    cbps_eval u_eval (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_not_empty),
        .i_job        (head_job),
        .o_job_pop    (pop),
        .i_pts        (r_pts),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_x   (o_sample_x),
        .o_sample_y   (o_sample_y),
        .o_step_index (o_step_index),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
